// File: hw/rtl/gfv_pkg.sv
`timescale 1ns / 1ps

package gfv_pkg;

  // Field and datapath widths
  localparam int unsigned PW    = 32;   // positions, masses, gain
  localparam int unsigned DW    = 33;   // |source - body| per axis
  localparam int unsigned SQW   = 66;   // dx^2 + dy^2 + dz^2
  localparam int unsigned NPAIR = SQW / 2;  // root digits, one per cell
  localparam int unsigned RW    = NPAIR;    // floor(sqrt(S))
  localparam int unsigned REMW  = RW + 1;   // root remainder
  localparam int unsigned SCW   = 128;  // G * m_body * m_source * gain
  localparam int unsigned NW    = 160;  // scale * |d|
  localparam int unsigned DENW  = 115;  // S * R * 2^16
  localparam int unsigned QW    = 64;   // quotient / force width
  localparam int unsigned NDIV  = QW;   // divider cells, one per quotient bit

  // round(6.67430e-11 * 2^64)
  localparam logic [30:0] G_Q64 = 31'd1231191040;

  typedef enum logic [2:0] {
    REG_SRC_X    = 3'd0,
    REG_SRC_Y    = 3'd1,
    REG_SRC_Z    = 3'd2,
    REG_SRC_MASS = 3'd3,
    REG_GAIN     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] neg;   // per-axis sign of source - body
    logic       zero;  // body sits on the source
    logic [2:0] big;   // quotient would not fit in 64 bits
  } flags_t;

endpackage

// File: hw/rtl/gfv_sqrt_cell.sv
`timescale 1ns / 1ps

// One digit of a restoring integer square root.
module gfv_sqrt_cell
  import gfv_pkg::*;
#(
  parameter int unsigned PAIR = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SQW-1:0]   s_i,
  input  logic [RW-1:0]    root_i,
  input  logic [REMW-1:0]  rem_i,
  output logic [SQW-1:0]   s_o,
  output logic [RW-1:0]    root_o,
  output logic [REMW-1:0]  rem_o
);

  logic [REMW+1:0] t;
  logic [REMW+1:0] trial;
  logic            take;

  assign t     = {rem_i, s_i[2*PAIR +: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign take  = (t >= trial);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_o    <= s_i;
      root_o <= {root_i[RW-2:0], take};
      rem_o  <= take ? REMW'(t - trial) : REMW'(t);
    end
  end

endmodule

// File: hw/rtl/gfv_div_cell.sv
`timescale 1ns / 1ps

// One quotient bit of a restoring divider; dividend bits shift out of nq
// while quotient bits shift in.
module gfv_div_cell
  import gfv_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DENW-1:0] den_i,
  input  logic [DENW-1:0] rem_i,
  input  logic [QW-1:0]   nq_i,
  output logic [DENW-1:0] den_o,
  output logic [DENW-1:0] rem_o,
  output logic [QW-1:0]   nq_o
);

  logic [DENW:0] t;
  logic          take;

  assign t    = {rem_i, nq_i[QW-1]};
  assign take = (t >= {1'b0, den_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      rem_o <= take ? DENW'(t - {1'b0, den_i}) : DENW'(t);
      nq_o  <= {nq_i[QW-2:0], take};
    end
  end

endmodule

// File: hw/rtl/gravity_force_vector.sv
`timescale 1ns / 1ps

// Gravitational force that a configured point source exerts on a body.
// Each input transfer carries one body (Q16.16 position, integer mass);
// each output transfer carries the force toward the source in Q32.32,
// G*m_body*m_source*gain*d/|d|^3, clamped to the 64-bit signed range with
// 'saturated' set when any axis clamps. A body on top of the source gives
// zero force with 'zero_distance' set. Throughput is one body per clock
// while in_stall_o is low. The pipeline has six multiply/add stages, a
// 33-cell square-root chain (one root digit per cell), three stages that
// build the divisor, and three parallel 64-cell divider chains (one
// quotient bit per cell), then the output register.
// The pipeline advances whenever its last stage is empty or the output
// register is free or being drained, so bodies keep entering while a
// result waits. Source registers may only be written while the pipeline
// is empty; the config port never stalls (cfg_ready_o is tied high).
module gravity_force_vector
  import gfv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [PW-1:0]        cfg_data_i,
  // body in
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [PW-1:0] body_x_i,
  input  logic signed [PW-1:0] body_y_i,
  input  logic signed [PW-1:0] body_z_i,
  input  logic [PW-1:0]        body_mass_i,
  // force out
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [QW-1:0] force_x_o,
  output logic signed [QW-1:0] force_y_o,
  output logic signed [QW-1:0] force_z_o,
  output logic                 zero_distance_o,
  output logic                 saturated_o
);

  localparam int unsigned SQ0  = 6;             // first root cell stage
  localparam int unsigned D1   = SQ0 + NPAIR;   // divisor partial products
  localparam int unsigned D2   = D1 + 1;        // divisor sum
  localparam int unsigned D3   = D2 + 1;        // overflow check, divider load
  localparam int unsigned NSTG = D3 + 1 + NDIV;

  // ---------------------------------------------------------------- config
  logic [PW-1:0] src_q [3];
  logic [PW-1:0] src_mass_q;
  logic [PW-1:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q[0]   <= '0;
      src_q[1]   <= '0;
      src_q[2]   <= '0;
      src_mass_q <= PW'(1);
      gain_q     <= PW'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SRC_X:    src_q[0]   <= cfg_data_i;
        REG_SRC_Y:    src_q[1]   <= cfg_data_i;
        REG_SRC_Z:    src_q[2]   <= cfg_data_i;
        REG_SRC_MASS: src_mass_q <= cfg_data_i;
        REG_GAIN:     gain_q     <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  logic          en;
  logic [NSTG-1:0] vld_q;
  logic          out_valid_q;
  logic          load;
  logic          take;

  // global pipeline enable: last stage empty, or output free / draining
  assign en         = !vld_q[NSTG-1] || !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign load       = en && vld_q[NSTG-1];
  assign take       = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------------------------------- stage 1: axis differences
  logic [PW-1:0] bod [3];
  logic [DW-1:0] dif [3];
  logic [DW-1:0] s1_ax_q [3];
  logic [2:0]    s1_neg_q;
  logic [PW-1:0] s1_bm_q;

  assign bod[0] = body_x_i;
  assign bod[1] = body_y_i;
  assign bod[2] = body_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {src_q[i][PW-1], src_q[i]} - {bod[i][PW-1], bod[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg_q[i] <= dif[i][DW-1];
        s1_ax_q[i]  <= dif[i][DW-1] ? (~dif[i] + DW'(1)) : dif[i];
      end
      s1_bm_q <= body_mass_i;
    end
  end

  // ------------------------- stage 2: squares, G*m_body, m_source*gain
  logic [SQW-1:0] s2_sq_q [3];
  logic [DW-1:0]  s2_ax_q [3];
  logic [2:0]     s2_neg_q;
  logic [62:0]    s2_gbm_q;
  logic [63:0]    s2_smg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= SQW'(s1_ax_q[i]) * SQW'(s1_ax_q[i]);
      end
      s2_ax_q  <= s1_ax_q;
      s2_neg_q <= s1_neg_q;
      s2_gbm_q <= 63'(G_Q64) * 63'(s1_bm_q);
      s2_smg_q <= 64'(src_mass_q) * 64'(gain_q);
    end
  end

  // --------------------------- stage 3: S, scale partial products
  logic [SQW-1:0] s3_s_q;
  logic [DW-1:0]  s3_ax_q [3];
  logic [2:0]     s3_neg_q;
  logic [63:0]    s3_pp_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_s_q     <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_ax_q    <= s2_ax_q;
      s3_neg_q   <= s2_neg_q;
      s3_pp_q[0] <= 64'(s2_gbm_q[31:0])  * 64'(s2_smg_q[31:0]);
      s3_pp_q[1] <= 64'(s2_gbm_q[31:0])  * 64'(s2_smg_q[63:32]);
      s3_pp_q[2] <= 64'(s2_gbm_q[62:32]) * 64'(s2_smg_q[31:0]);
      s3_pp_q[3] <= 64'(s2_gbm_q[62:32]) * 64'(s2_smg_q[63:32]);
    end
  end

  // ------------------------------------------- stage 4: scale sum
  logic [SQW-1:0] s4_s_q;
  logic [DW-1:0]  s4_ax_q [3];
  logic [2:0]     s4_neg_q;
  logic [SCW-1:0] s4_scale_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_s_q     <= s3_s_q;
      s4_ax_q    <= s3_ax_q;
      s4_neg_q   <= s3_neg_q;
      s4_scale_q <= SCW'(s3_pp_q[0]) + (SCW'(s3_pp_q[1]) << 32)
                  + (SCW'(s3_pp_q[2]) << 32) + (SCW'(s3_pp_q[3]) << 64);
    end
  end

  // --------------------- stage 5: numerator partials, scale * |d|
  logic [SQW-1:0] s5_s_q;
  logic [2:0]     s5_neg_q;
  logic [DW+31:0] s5_pp_q [3][4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_s_q   <= s4_s_q;
      s5_neg_q <= s4_neg_q;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 4; k++) begin
          s5_pp_q[i][k] <= (DW+32)'(s4_scale_q[32*k +: 32]) * (DW+32)'(s4_ax_q[i]);
        end
      end
    end
  end

  // ---------------------------------------- stage 6: numerator sum
  logic [SQW-1:0] s6_s_q;
  logic [2:0]     s6_neg_q;
  logic [NW-1:0]  s6_num_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_s_q   <= s5_s_q;
      s6_neg_q <= s5_neg_q;
      for (int i = 0; i < 3; i++) begin
        s6_num_q[i] <= NW'(s5_pp_q[i][0]) + (NW'(s5_pp_q[i][1]) << 32)
                     + (NW'(s5_pp_q[i][2]) << 64) + (NW'(s5_pp_q[i][3]) << 96);
      end
    end
  end

  // ------------------------------------------------ square-root chain
  logic [SQW-1:0]  sq_s    [NPAIR+1];
  logic [RW-1:0]   sq_root [NPAIR+1];
  logic [REMW-1:0] sq_rem  [NPAIR+1];
  logic [NW-1:0]   sqs_num_q [NPAIR][3];
  logic [2:0]      sqs_neg_q [NPAIR];

  assign sq_s[0]    = s6_s_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar k = 0; k < NPAIR; k++) begin : g_sqrt
    gfv_sqrt_cell #(
      .PAIR (NPAIR - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .s_i    (sq_s[k]),
      .root_i (sq_root[k]),
      .rem_i  (sq_rem[k]),
      .s_o    (sq_s[k+1]),
      .root_o (sq_root[k+1]),
      .rem_o  (sq_rem[k+1])
    );
  end

  // numerators and signs ride alongside the root cells
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqs_num_q[0] <= s6_num_q;
      sqs_neg_q[0] <= s6_neg_q;
      for (int k = 1; k < NPAIR; k++) begin
        sqs_num_q[k] <= sqs_num_q[k-1];
        sqs_neg_q[k] <= sqs_neg_q[k-1];
      end
    end
  end

  // ------------------------------------ D1: S * R partial products
  logic [SQW-1:0] d1_plo_q;
  logic [SQW-1:0] d1_phi_q;
  logic [NW-1:0]  d1_num_q [3];
  logic [2:0]     d1_neg_q;
  logic           d1_zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_plo_q  <= SQW'(sq_s[NPAIR][32:0])  * SQW'(sq_root[NPAIR]);
      d1_phi_q  <= SQW'(sq_s[NPAIR][65:33]) * SQW'(sq_root[NPAIR]);
      d1_num_q  <= sqs_num_q[NPAIR-1];
      d1_neg_q  <= sqs_neg_q[NPAIR-1];
      d1_zero_q <= (sq_s[NPAIR] == '0);
    end
  end

  // ------------------------------------- D2: divisor S * R * 2^16
  logic [DENW-17:0] prod;
  logic [DENW-1:0]  d2_den_q;
  logic [NW-1:0]    d2_num_q [3];
  logic [2:0]       d2_neg_q;
  logic             d2_zero_q;

  assign prod = ((DENW-16)'(d1_phi_q) << 33) + (DENW-16)'(d1_plo_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_den_q  <= {prod, 16'h0000};
      d2_num_q  <= d1_num_q;
      d2_neg_q  <= d1_neg_q;
      d2_zero_q <= d1_zero_q;
    end
  end

  // ------------- D3: overflow test (q >= 2^64) and divider load
  logic [DENW-1:0] d3_den_q;
  logic [DENW-1:0] d3_rem_q [3];
  logic [QW-1:0]   d3_nq_q  [3];
  flags_t          d3_flg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_den_q      <= d2_den_q;
      d3_flg_q.neg  <= d2_neg_q;
      d3_flg_q.zero <= d2_zero_q;
      for (int i = 0; i < 3; i++) begin
        d3_flg_q.big[i] <= (DENW'(d2_num_q[i][NW-1:QW]) >= d2_den_q);
        d3_rem_q[i]     <= DENW'(d2_num_q[i][NW-1:QW]);
        d3_nq_q[i]      <= d2_num_q[i][QW-1:0];
      end
    end
  end

  // ------------------------------------------ divider chains, one per axis
  logic [DENW-1:0] dv_den [3][NDIV+1];
  logic [DENW-1:0] dv_rem [3][NDIV+1];
  logic [QW-1:0]   dv_nq  [3][NDIV+1];
  flags_t          dvf_q  [NDIV];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign dv_den[l][0] = d3_den_q;
    assign dv_rem[l][0] = d3_rem_q[l];
    assign dv_nq[l][0]  = d3_nq_q[l];
    for (genvar k = 0; k < NDIV; k++) begin : g_div
      gfv_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .den_i (dv_den[l][k]),
        .rem_i (dv_rem[l][k]),
        .nq_i  (dv_nq[l][k]),
        .den_o (dv_den[l][k+1]),
        .rem_o (dv_rem[l][k+1]),
        .nq_o  (dv_nq[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvf_q[0] <= d3_flg_q;
      for (int k = 1; k < NDIV; k++) begin
        dvf_q[k] <= dvf_q[k-1];
      end
    end
  end

  // ------------------------------------- sign, clamp, output register
  // returns {clamped, value}
  function automatic logic [QW:0] fmt(input logic [QW-1:0] q, input logic neg,
                                      input logic big);
    logic over;
    logic [QW:0] r;
    if (!neg) begin
      over = big || q[QW-1];
      r    = over ? {1'b1, 1'b0, {(QW-1){1'b1}}} : {1'b0, q};
    end else begin
      over = big || (q[QW-1] && (|q[QW-2:0]));
      r    = over ? {1'b1, 1'b1, {(QW-1){1'b0}}} : {1'b0, QW'(0) - q};
    end
    return r;
  endfunction

  flags_t        lst;
  logic [QW:0]   res [3];
  logic [QW-1:0] force_q [3];
  logic          zero_q;
  logic          sat_q;

  assign lst = dvf_q[NDIV-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = fmt(dv_nq[i][NDIV], lst.neg[i], lst.big[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      zero_q <= lst.zero;
      sat_q  <= !lst.zero && (res[0][QW] || res[1][QW] || res[2][QW]);
      for (int i = 0; i < 3; i++) begin
        force_q[i] <= lst.zero ? '0 : res[i][QW-1:0];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign force_x_o       = force_q[0];
  assign force_y_o       = force_q[1];
  assign force_z_o       = force_q[2];
  assign zero_distance_o = zero_q;
  assign saturated_o     = sat_q;

endmodule

// File: hw/rtl/gfv_checker.sv
`timescale 1ns / 1ps

module gfv_checker
  import gfv_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [QW-1:0] force_x_o,
  input logic signed [QW-1:0] force_y_o,
  input logic signed [QW-1:0] force_z_o,
  input logic                 zero_distance_o,
  input logic                 saturated_o
);

  localparam logic [QW-1:0] FMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] FMIN = {1'b1, {(QW-1){1'b0}}};

  // stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result does not change
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(force_x_o) && $stable(force_y_o)
                                 && $stable(force_z_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // coincident body: zero force, no clamp
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_distance_o |-> force_x_o == '0 && force_y_o == '0
                                       && force_z_o == '0 && !saturated_o)
    else $error("nonzero force at zero distance");

  // a clamp shows up as a rail value on some axis
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      force_x_o == FMAX || force_x_o == FMIN || force_y_o == FMAX
      || force_y_o == FMIN || force_z_o == FMAX || force_z_o == FMIN)
    else $error("saturated flag without a clamped component");

endmodule

bind gravity_force_vector gfv_checker u_gfv_checker (.*);
